>>> rtl/core/stfw_pkg.sv
// Shared types and constants for the semaphore table with FIFO wait queues.
// Depends on nothing; stfw_table and the top level refer to it by scoped name.
package stfw_pkg;

  localparam int NUM_SEMS   = 16;
  localparam int NUM_PROCS  = 16;

  localparam int SEM_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PROC_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int LEN_W      = $clog2(NUM_PROCS + 1);
  localparam int FIFO_DEPTH = NUM_SEMS * NUM_PROCS;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // Field widths of one word on either channel
  localparam int CMD_W      = 2;
  localparam int PID_W      = 8;
  localparam int SIDX_W     = 4;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 3;
  // Wide enough to compare a semaphore index against a table size of up to 511
  localparam int SCHK_W     = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_NOTALLOC = 3'd3,
    ST_QFULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PID_W-1:0]   proc_id;
    logic [SIDX_W-1:0]  sem_index;
    logic [COUNT_W-1:0] init_count;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [SIDX_W-1:0] alloc_index;
    logic              wake_valid;
  } dec_t;

  typedef struct packed {
    logic               we;
    logic [FIFO_AW-1:0] waddr;
    logic [PID_W-1:0]   wdata;
    logic [FIFO_AW-1:0] raddr;
  } fifo_req_t;

endpackage

>>> rtl/core/stfw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the per-semaphore wait queues.
module stfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/stfw_table.sv
// Semaphore state table: in-use flags, counts, queue heads and lengths,
// plus the command decision. Depends on stfw_pkg.
module stfw_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  stfw_pkg::item_t    item,
  output stfw_pkg::dec_t     dec,
  output stfw_pkg::fifo_req_t fifo
);

  logic                                 in_use_r [stfw_pkg::NUM_SEMS];
  logic [stfw_pkg::COUNT_W-1:0]         cnt_r    [stfw_pkg::NUM_SEMS];
  logic [stfw_pkg::PROC_W-1:0]          head_r   [stfw_pkg::NUM_SEMS];
  logic [stfw_pkg::LEN_W-1:0]           len_r    [stfw_pkg::NUM_SEMS];

  logic                                 free_found;
  logic [stfw_pkg::SEM_W-1:0]           free_idx;
  logic [stfw_pkg::SEM_W-1:0]           sem;
  logic                                 sem_ok;
  logic [stfw_pkg::COUNT_W-1:0]         cur_cnt;
  logic [stfw_pkg::PROC_W-1:0]          cur_head;
  logic [stfw_pkg::LEN_W-1:0]           cur_len;
  logic [stfw_pkg::PROC_W:0]            tail_sum;
  logic [stfw_pkg::PROC_W-1:0]          tail;
  logic [stfw_pkg::PROC_W-1:0]          head_nxt;
  logic [stfw_pkg::COUNT_W-1:0]         cnt_nxt;
  logic [stfw_pkg::FIFO_AW-1:0]         fifo_base;
  logic                                 do_alloc;
  logic                                 do_cnt;
  logic                                 do_push;
  logic                                 do_pop;

  // Lowest free semaphore: scan downwards so the lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = stfw_pkg::NUM_SEMS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = stfw_pkg::SEM_W'(i);
      end
    end
  end

  assign sem      = stfw_pkg::SEM_W'(item.sem_index);
  assign sem_ok   = (stfw_pkg::SCHK_W'(item.sem_index) < stfw_pkg::SCHK_W'(stfw_pkg::NUM_SEMS))
                    && in_use_r[sem];
  assign cur_cnt  = cnt_r[sem];
  assign cur_head = head_r[sem];
  assign cur_len  = len_r[sem];

  // Queue tail wraps once at most: head stays below the depth and length never exceeds it
  assign tail_sum = (stfw_pkg::PROC_W + 1)'(cur_head) + (stfw_pkg::PROC_W + 1)'(cur_len);
  assign tail     = (tail_sum >= (stfw_pkg::PROC_W + 1)'(stfw_pkg::NUM_PROCS))
                    ? stfw_pkg::PROC_W'(tail_sum - (stfw_pkg::PROC_W + 1)'(stfw_pkg::NUM_PROCS))
                    : stfw_pkg::PROC_W'(tail_sum);
  assign head_nxt = (cur_head == stfw_pkg::PROC_W'(stfw_pkg::NUM_PROCS - 1))
                    ? '0 : cur_head + stfw_pkg::PROC_W'(1);

  assign fifo_base = stfw_pkg::FIFO_AW'(stfw_pkg::FIFO_AW'(sem)
                                        * stfw_pkg::FIFO_AW'(stfw_pkg::NUM_PROCS));

  always_comb begin
    dec.status      = stfw_pkg::ST_OK;
    dec.alloc_index = '0;
    dec.wake_valid  = 1'b0;
    do_alloc        = 1'b0;
    do_cnt          = 1'b0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    cnt_nxt         = cur_cnt;
    unique case (item.cmd) inside
      stfw_pkg::CMD_ALLOC: begin
        if (!free_found) begin
          dec.status = stfw_pkg::ST_NOFREE;
        end else begin
          do_alloc        = 1'b1;
          dec.alloc_index = stfw_pkg::SIDX_W'(free_idx);
        end
      end
      stfw_pkg::CMD_WAIT, stfw_pkg::CMD_SIGNAL: begin
        if (!sem_ok) begin
          dec.status = stfw_pkg::ST_NOTALLOC;
        end else if (item.cmd == stfw_pkg::CMD_WAIT) begin
          if (cur_cnt != '0) begin
            do_cnt  = 1'b1;
            cnt_nxt = cur_cnt - stfw_pkg::COUNT_W'(1);
          end else if (cur_len >= stfw_pkg::LEN_W'(stfw_pkg::NUM_PROCS)) begin
            dec.status = stfw_pkg::ST_QFULL;
          end else begin
            do_push    = 1'b1;
            dec.status = stfw_pkg::ST_BLOCKED;
          end
        end else begin
          if (cur_len != '0) begin
            do_pop         = 1'b1;
            dec.wake_valid = 1'b1;
          end else if (cur_cnt != stfw_pkg::COUNT_MAX) begin
            do_cnt  = 1'b1;
            cnt_nxt = cur_cnt + stfw_pkg::COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign fifo.we    = commit && do_push;
  assign fifo.waddr = fifo_base + stfw_pkg::FIFO_AW'(tail);
  assign fifo.wdata = item.proc_id;
  assign fifo.raddr = fifo_base + stfw_pkg::FIFO_AW'(cur_head);

  // In-use flags are the only state cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < stfw_pkg::NUM_SEMS; i++) begin
        in_use_r[i] <= 1'b0;
      end
    end else if (commit && do_alloc) begin
      in_use_r[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (do_alloc) begin
        cnt_r[free_idx]  <= item.init_count;
        head_r[free_idx] <= '0;
        len_r[free_idx]  <= '0;
      end
      if (do_cnt) begin
        cnt_r[sem] <= cnt_nxt;
      end
      if (do_push) begin
        len_r[sem] <= cur_len + stfw_pkg::LEN_W'(1);
      end
      if (do_pop) begin
        head_r[sem] <= head_nxt;
        len_r[sem]  <= cur_len - stfw_pkg::LEN_W'(1);
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    fifo.we |-> cur_len < stfw_pkg::LEN_W'(stfw_pkg::NUM_PROCS))
    else $error("enqueue into a full wait queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    commit && dec.wake_valid |-> sem_ok && cur_len != '0)
    else $error("wake from an empty or unallocated queue");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit && do_alloc |-> !in_use_r[free_idx])
    else $error("allocate claimed a semaphore already in use");

endmodule

>>> rtl/core/semaphore_table_fifo_wait.sv
// Top level of the counting semaphore table with per-semaphore FIFO wait queues.
// Depends on stfw_pkg, stfw_table and stfw_ram.
//
// Usage
//   Input channel (in_*): one word per kernel call. in_cmd selects allocate,
//   wait or signal; in_proc_id, in_sem_index and in_init_count carry operands.
//   Output channel (out_*): exactly one result word per input word, in order.
//   out_status reports ok, no free semaphore, caller blocked, semaphore not
//   allocated or queue full; out_alloc_index names the claimed semaphore;
//   out_wake_valid with out_wake_proc names the process a signal released.
// Timing
//   A word accepted at one edge lands in the input register; the table is
//   read and decided from it combinationally. When the result slot is free,
//   the table update, the result register and the wait-queue RAM read port
//   (for wake_proc) are all loaded at the same edge, which moves the word
//   out of stage one. Throughput is one word per cycle while the receiver
//   keeps taking results: the table update and the queue RAM read/write each
//   finish at the edge that moves an item out of stage one.
// Reset and stall
//   Reset empties both stages and frees every semaphore; counts, heads and
//   lengths are written by allocate, and queue slots by a blocked wait, before any use.
//   When the receiver stalls, hold the result and stage one; in_ready drops
//   only once both registers are full.
module semaphore_table_fifo_wait (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stfw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [stfw_pkg::PID_W-1:0]    in_proc_id,
  input  logic [stfw_pkg::SIDX_W-1:0]   in_sem_index,
  input  logic [stfw_pkg::COUNT_W-1:0]  in_init_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stfw_pkg::STATUS_W-1:0] out_status,
  output logic [stfw_pkg::SIDX_W-1:0]   out_alloc_index,
  output logic                          out_wake_valid,
  output logic [stfw_pkg::PID_W-1:0]    out_wake_proc
);

  // Stage one: the accepted word waiting for its table pass
  logic                s1_v_r;
  stfw_pkg::item_t     s1_item_r;

  // Stage two: result register
  logic                out_valid_r;
  stfw_pkg::status_t   out_status_r;
  logic [stfw_pkg::SIDX_W-1:0] out_alloc_r;
  logic                out_wake_v_r;

  logic                adv;
  logic                commit;
  stfw_pkg::dec_t      dec;
  stfw_pkg::fifo_req_t fifo;
  logic [stfw_pkg::PID_W-1:0] fifo_rdata;

  // Result slot is free, or is being taken this cycle
  assign adv      = !out_valid_r || out_ready;
  // Stage one word is decided and its state changes committed
  assign commit   = s1_v_r && adv;
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  // Payload registers: no reset, load on handshake or commit only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.cmd        <= in_cmd;
      s1_item_r.proc_id    <= in_proc_id;
      s1_item_r.sem_index  <= in_sem_index;
      s1_item_r.init_count <= in_init_count;
    end
    if (commit) begin
      out_status_r <= dec.status;
      out_alloc_r  <= dec.alloc_index;
      out_wake_v_r <= dec.wake_valid;
    end
  end

  stfw_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (s1_item_r),
    .dec    (dec),
    .fifo   (fifo)
  );

  // Wait queues: read the head slot on every commit, so the data lines up
  // with the result register and holds while the receiver stalls
  stfw_ram #(
    .WIDTH (stfw_pkg::PID_W),
    .DEPTH (stfw_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo.we),
    .waddr (fifo.waddr),
    .wdata (fifo.wdata),
    .re    (commit),
    .raddr (fifo.raddr),
    .rdata (fifo_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_alloc_index = out_alloc_r;
  assign out_wake_valid  = out_wake_v_r;
  // Drop stale RAM data when nothing was released
  assign out_wake_proc   = out_wake_v_r ? fifo_rdata : '0;

  a_wake_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wake_v_r |-> out_status_r == stfw_pkg::ST_OK && out_alloc_r == '0)
    else $error("wake reported with a non-ok status or an alloc index");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input refused with stage one empty");

  a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed word produced no result");

endmodule
